@@ design/fbss_pkg.sv @@
// Shared constants and types for the fuzzy byte signature search block.
`timescale 1ns / 1ps

package fbss_pkg;

  localparam int WIN_DEPTH     = 32;   // largest signature the block supports
  localparam int BYTES_PER_REG = 8;    // signature bytes held by one config register
  localparam int SIG_REGS      = 4;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int THRESH_W      = 6;
  localparam int CNT_W         = 6;    // holds a hit count up to WIN_DEPTH
  localparam int GRP_SIZE      = 8;    // cells summed per first-level adder
  localparam int GRP_SUM_W     = 4;    // holds a count up to GRP_SIZE
  localparam int OFS_W         = 32;

  localparam logic [OFS_W-1:0]    SEEN_SAT       = '1;
  localparam logic [THRESH_W-1:0] DEFAULT_THRESH = THRESH_W'(31);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIG_0_7   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_8_15  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_16_23 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_24_31 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH    = 3'd4;

  typedef logic [SIG_REGS-1:0][CFG_DATA_W-1:0] sig_regs_t;

  // bookkeeping that travels beside the score through the pipeline
  typedef struct packed {
    logic             eligible;   // window full and count not saturated
    logic             last;       // beat closes the region
    logic [OFS_W-1:0] offset;     // region offset of the window's first byte
  } beat_meta_t;

endpackage

@@ design/fbss_channels.sv @@
// Valid/ready channel interfaces for the byte stream and the search result.
`timescale 1ns / 1ps

interface fbss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       region_end;

  modport source (output valid, output data_byte, output region_end, input ready);
  modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

interface fbss_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [fbss_pkg::OFS_W-1:0] win_start;

  modport source (output valid, output found, output win_start, input ready);
  modport sink   (input valid, input found, input win_start, output ready);
endinterface

@@ design/fbss_cell.sv @@
// One window position: holds a byte, compares it against its signature byte.
`timescale 1ns / 1ps

module fbss_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] byte_in,
  input  logic [7:0] sig_byte,
  output logic [7:0] byte_out,
  output logic       hit
);

  logic [7:0] window_byte;
  logic       eq;

  // the compare is taken on the byte as it moves in, so hit always matches window_byte
  always_ff @(posedge clk) begin
    if (shift_en) begin
      window_byte <= byte_in;
      eq          <= (byte_in == sig_byte);
    end
  end

  assign byte_out = window_byte;
  assign hit      = eq;

endmodule

@@ design/fbss_score.sv @@
// First level of the hit count: registered partial sums over groups of cells.
`timescale 1ns / 1ps

module fbss_score #(
  parameter int SIG_BYTES = fbss_pkg::WIN_DEPTH,
  parameter int GROUPS    = (SIG_BYTES + fbss_pkg::GRP_SIZE - 1) / fbss_pkg::GRP_SIZE
) (
  input  logic                                      clk,
  input  logic                                      load,
  input  logic [SIG_BYTES-1:0]                      hits,
  output logic [GROUPS-1:0][fbss_pkg::GRP_SUM_W-1:0] grp_sums
);

  import fbss_pkg::*;

  logic [GROUPS-1:0][GRP_SUM_W-1:0] sums_next;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      sums_next[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < SIG_BYTES) begin
          sums_next[g] = sums_next[g] + GRP_SUM_W'(hits[g * GRP_SIZE + k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_sums <= sums_next;
    end
  end

endmodule

@@ design/fuzzy_byte_signature_search.sv @@
// Top level of the fuzzy byte signature search: cell row, scoring pipeline, result register.
`timescale 1ns / 1ps

// Streams the bytes of a region, one beat per byte, and reports the first
// window of SIGNATURE_BYTES consecutive bytes in which at least
// match_threshold positions equal the configured signature. A region gives
// exactly one result beat: found=1 with the offset of the window's first
// byte, or found=0 / offset 0 on the region's last byte when nothing matched.
// Throughput is one byte per clock while the pipeline is not backed up. A
// byte passes three register stages: the cell row (shift and per-byte
// compare) when it is accepted, then the partial hit sums, then the final
// add, threshold compare and result register, from which its result is
// offered. The block keeps taking bytes while a result waits on the output;
// it only stops when every pipeline stage is full behind a stalled result.
// Configuration is written through cfg_we/cfg_index/cfg_data while no beat
// is in flight; writes to unknown indexes are dropped. The byte counter
// saturates at 2^32-1; past that no further window of the region is examined.
module fuzzy_byte_signature_search #(
  parameter int SIGNATURE_BYTES = fbss_pkg::WIN_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fbss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fbss_pkg::CFG_DATA_W-1:0]      cfg_data,
  fbss_in_if.sink                             din,
  fbss_out_if.source                          dout
);

  import fbss_pkg::*;

  localparam int GROUPS = (SIGNATURE_BYTES + GRP_SIZE - 1) / GRP_SIZE;

  // ---------------- configuration ----------------
  sig_regs_t           sig_q;
  logic [THRESH_W-1:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      sig_q     <= '0;
      threshold <= DEFAULT_THRESH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIG_0_7:   sig_q[0]  <= cfg_data;
        REG_SIG_8_15:  sig_q[1]  <= cfg_data;
        REG_SIG_16_23: sig_q[2]  <= cfg_data;
        REG_SIG_24_31: sig_q[3]  <= cfg_data;
        REG_THRESH:    threshold <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic s1_valid, s2_valid, out_valid;
  logic s1_adv, s2_adv, accept;

  assign s2_adv    = !out_valid || dout.ready;
  assign s1_adv    = !s2_valid || s2_adv;
  assign din.ready = !s1_valid || s1_adv;
  assign accept    = din.valid && din.ready;

  // ---------------- front: byte count per region ----------------
  logic [OFS_W-1:0] bytes_seen;
  logic [OFS_W-1:0] seen_inc;
  logic             saturated;
  beat_meta_t       meta_in;

  assign saturated = (bytes_seen == SEEN_SAT);
  assign seen_inc  = saturated ? bytes_seen : bytes_seen + OFS_W'(1);

  always_comb begin
    meta_in.eligible = !saturated && (seen_inc >= OFS_W'(SIGNATURE_BYTES));
    meta_in.last     = din.region_end;
    meta_in.offset   = seen_inc - OFS_W'(SIGNATURE_BYTES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
    end else if (accept) begin
      bytes_seen <= din.region_end ? '0 : seen_inc;
    end
  end

  // ---------------- cell row: newest byte enters the top cell ----------------
  logic [SIGNATURE_BYTES:0][7:0] chain;
  logic [SIGNATURE_BYTES-1:0]    hits;

  assign chain[SIGNATURE_BYTES] = din.data_byte;

  for (genvar j = 0; j < SIGNATURE_BYTES; j++) begin : g_cell
    fbss_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .byte_in  (chain[j+1]),
      .sig_byte (sig_q[j / BYTES_PER_REG][(j % BYTES_PER_REG) * 8 +: 8]),
      .byte_out (chain[j]),
      .hit      (hits[j])
    );
  end

  // stage 1 control sits beside the cell row
  beat_meta_t s1_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta <= meta_in;
    end
  end

  // ---------------- stage 2: partial sums ----------------
  logic                             s2_load;
  logic [GROUPS-1:0][GRP_SUM_W-1:0] grp_sums;
  beat_meta_t                       s2_meta;

  assign s2_load = s1_valid && s1_adv;

  fbss_score #(
    .SIG_BYTES (SIGNATURE_BYTES),
    .GROUPS    (GROUPS)
  ) u_score (
    .clk      (clk),
    .load     (s2_load),
    .hits     (hits),
    .grp_sums (grp_sums)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_meta <= s1_meta;
    end
  end

  // ---------------- stage 3: decide and register result ----------------
  logic [CNT_W-1:0] total;
  logic             already_found;
  logic             hit_now;
  logic             miss_now;
  logic             s2_fire;
  logic             out_found;
  logic [OFS_W-1:0] out_offset;

  always_comb begin
    total = '0;
    for (int g = 0; g < GROUPS; g++) begin
      total = total + CNT_W'(grp_sums[g]);
    end
  end

  assign s2_fire  = s2_valid && s2_adv;
  assign hit_now  = s2_meta.eligible && !already_found && (total >= threshold);
  assign miss_now = s2_meta.last && !already_found && !hit_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      already_found <= 1'b0;
    end else if (s2_fire) begin
      already_found <= s2_meta.last ? 1'b0 : (already_found || hit_now);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_fire && (hit_now || miss_now)) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && (hit_now || miss_now)) begin
      out_found  <= hit_now;
      out_offset <= hit_now ? s2_meta.offset : '0;
    end
  end

  assign dout.valid     = out_valid;
  assign dout.found     = out_found;
  assign dout.win_start = out_offset;

  // ---------------- checks ----------------
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.found |-> dout.win_start == '0)
    else $error("not-found beat with nonzero offset");

  a_count_clears: assert property (@(posedge clk) disable iff (rst)
    accept && din.region_end |=> bytes_seen == '0)
    else $error("byte count not cleared after region end");

  a_found_clears: assert property (@(posedge clk) disable iff (rst)
    s2_fire && s2_meta.last |=> !already_found)
    else $error("found flag survived region end");

  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_adv |=> s2_valid && $stable(s2_meta))
    else $error("stalled score stage lost its beat");

  a_no_double_hit: assert property (@(posedge clk) disable iff (rst)
    s2_valid && already_found |-> !hit_now)
    else $error("second match in one region");

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the fuzzy byte signature search block.
`timescale 1ns / 1ps

// Checks the block against a cycle-free model of the search kept in this file.
// The run has two parts. A short table of rows comes first: register settings
// and runs of bytes, with a few results typed in by hand. Then come random
// phases, each with its own register setting. Most phases send a handful of
// regions, most of them a copy of the signature with a few bytes flipped, set
// inside noise, so that the window count lands on both sides of the threshold;
// every fourth phase sends 24 regions of noise only, one to three bytes long.
// Both channels idle at random, and now and then the result side holds off long enough for the byte stream to back up.
module tb;
  import fbss_pkg::*;

  localparam int SIG_LEN        = WIN_DEPTH;   // block built with its default size
  localparam int RANDOM_BYTES   = 400;
  localparam int DRAIN_CYCLES   = 8;           // three-stage pipe plus margin
  localparam int SQUEEZE_CYCLES = 60;
  localparam int LIMIT_CYCLES   = 400000;

  typedef struct packed {
    logic             found;
    logic [OFS_W-1:0] offset;
  } verdict_t;

  typedef enum logic [2:0] {SIG_ZERO, SIG_ONES, SIG_RAMP, SIG_COMMON, SIG_RAND} sig_mode_t;

  // one row of the directed table: a register setting or a run of bytes
  typedef struct {
    bit                  setup;
    sig_mode_t           mode;
    logic [THRESH_W-1:0] thresh;
    bit                  junk;      // also write the unused register indexes
    logic [7:0]          base;
    logic [7:0]          stride;
    int unsigned         count;
    bit                  last;      // final byte of the run closes the region
    bit                  typed;     // final byte carries the hand-written result
    verdict_t            want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fbss_in_if  byte_ch ();
  fbss_out_if res_ch ();

  fuzzy_byte_signature_search u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (byte_ch),
    .dout      (res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Search model: its own copy of the registers, the window and the
  // per-region bookkeeping.
  // ---------------------------------------------------------------------
  sig_regs_t           mdl_sig;
  logic [THRESH_W-1:0] mdl_thresh;
  logic [7:0]          mdl_win [WIN_DEPTH];
  logic [OFS_W-1:0]    mdl_seen;
  bit                  mdl_done;   // region already reported a match

  verdict_t   pending_verdicts [$];
  plan_row_t  plan [$];
  logic [7:0] region_bytes [$];

  // run bookkeeping
  int unsigned cycle_count = 0;
  int unsigned n_bad = 0;
  int unsigned n_bytes = 0;
  int unsigned n_regions = 0;
  int unsigned n_settings = 0;
  int unsigned n_found = 0;
  int unsigned n_missed = 0;

  // idling controls
  bit          tx_idle;
  bit          rx_idle;
  int unsigned squeeze_req;
  int unsigned squeeze_done;
  int          rx_hold;
  int          rx_gap;

  task automatic clear_region_model();
    for (int i = 0; i < WIN_DEPTH; i++) mdl_win[i] = 8'h00;
    mdl_seen = '0;
    mdl_done = 1'b0;
  endtask

  // Shift one byte into the model window; got is set when the byte makes a result.
  task automatic score_byte(input logic [7:0] b, input logic last,
                            output bit got, output verdict_t v);
    int unsigned hits;
    bit          sat;
    sat = (mdl_seen == SEEN_SAT);
    got = 1'b0;
    v   = '0;
    for (int i = 0; i < WIN_DEPTH - 1; i++) mdl_win[i] = mdl_win[i + 1];
    mdl_win[WIN_DEPTH - 1] = b;
    // a saturated count stops further windows of the region from being scored;
    // reaching it takes 2^32-1 bytes, far beyond any run here
    if (!sat) mdl_seen = mdl_seen + 1'b1;
    if (!mdl_done && !sat && mdl_seen >= OFS_W'(SIG_LEN)) begin
      hits = 0;
      for (int j = 0; j < SIG_LEN; j++) begin
        if (mdl_win[WIN_DEPTH - SIG_LEN + j] ==
            mdl_sig[j / BYTES_PER_REG][(j % BYTES_PER_REG) * 8 +: 8]) hits++;
      end
      if (hits >= mdl_thresh) begin
        mdl_done = 1'b1;
        got      = 1'b1;
        v.found  = 1'b1;
        v.offset = mdl_seen - OFS_W'(SIG_LEN);
      end
    end
    if (last) begin
      // a match on the closing byte stands alone; a region with no match reports a miss
      if (!got && !mdl_done) begin
        got = 1'b1;
        v   = '0;
      end
      clear_region_model();
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  // bytes that signatures and noise share, so partial matches happen often
  function automatic logic [7:0] common_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hF4;
      2:       return 8'hFF;
      default: return 8'h3C;
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    return common_byte();
  endfunction

  function automatic sig_regs_t sig_pattern(input sig_mode_t mode);
    sig_regs_t  s;
    logic [7:0] b;
    s = '0;
    for (int j = 0; j < SIG_LEN; j++) begin
      case (mode)
        SIG_ZERO:   b = 8'h00;
        SIG_ONES:   b = 8'hFF;
        SIG_RAMP:   b = 8'(j);
        SIG_COMMON: b = common_byte();
        default:    b = 8'($urandom_range(0, 255));
      endcase
      s[j / BYTES_PER_REG][(j % BYTES_PER_REG) * 8 +: 8] = b;
    end
    return s;
  endfunction

  // cfg_we is left high; the caller lowers it after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_SIG_0_7, REG_SIG_8_15, REG_SIG_16_23, REG_SIG_24_31: mdl_sig[idx[1:0]] = val;
      REG_THRESH: mdl_thresh = val[THRESH_W-1:0];
      default: ;  // unused index: block must drop it
    endcase
  endtask

  task automatic apply_setting(input sig_regs_t s, input logic [THRESH_W-1:0] th,
                               input bit junk);
    logic [CFG_DATA_W-1:0] th_word;
    th_word = junk ? {$urandom, $urandom} : '0;   // upper bits must be ignored
    th_word[THRESH_W-1:0] = th;
    for (int r = 0; r < SIG_REGS; r++) write_reg(REG_SIG_0_7 + CFG_IDX_W'(r), s[r]);
    write_reg(REG_THRESH, th_word);
    if (junk) begin
      for (int k = REG_THRESH + 1; k < (1 << CFG_IDX_W); k++)
        write_reg(CFG_IDX_W'(k), {$urandom, $urandom});
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Wait until every predicted result is in, then let the pipe empty out:
  // bytes after a match give no result but may still be in flight.
  task automatic settle();
    byte_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input verdict_t want);
    verdict_t    v;
    bit          got;
    int unsigned gap;
    score_byte(b, last, got, v);
    if (typed) pending_verdicts.push_back(want);
    else if (got) pending_verdicts.push_back(v);
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.data_byte  <= b;
    byte_ch.region_end <= last;
    do @(posedge clk); while (!byte_ch.ready);
    n_bytes++;
    if (last) n_regions++;
  endtask

  task automatic send_region();
    for (int i = 0; i < region_bytes.size(); i++)
      send_byte(region_bytes[i], i == region_bytes.size() - 1, 1'b0, '0);
  endtask

  // Random region: mostly a lightly damaged signature copy in noise; tiny: 1-3 noise bytes.
  task automatic build_region(input bit tiny);
    int unsigned shape;
    int unsigned lead;
    int unsigned tail;
    int unsigned flips;
    int unsigned len;
    logic [7:0]  b;
    region_bytes.delete();
    shape = tiny ? 100 : $urandom_range(0, 19);
    if (shape < 12) begin
      lead  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 6);
      flips = $urandom_range(0, 6);
      tail  = $urandom_range(0, 8);
      repeat (lead) region_bytes.push_back(noise_byte());
      for (int j = 0; j < SIG_LEN; j++) begin
        b = mdl_sig[j / BYTES_PER_REG][(j % BYTES_PER_REG) * 8 +: 8];
        if ($urandom_range(0, 31) < flips) b = b ^ 8'($urandom_range(1, 255));
        region_bytes.push_back(b);
      end
      repeat (tail) region_bytes.push_back(noise_byte());
    end else begin
      if (tiny) len = $urandom_range(1, 3);
      else if (shape < 16) len = $urandom_range(1, 70);
      else if (shape < 19) len = $urandom_range(1, SIG_LEN - 1);   // never fills a window
      else len = $urandom_range(100, 300);
      repeat (len) region_bytes.push_back(noise_byte());
    end
  endtask

  task automatic plan_setup(input sig_mode_t mode, input int unsigned th, input bit junk);
    plan_row_t r;
    r.setup  = 1'b1;
    r.mode   = mode;
    r.thresh = THRESH_W'(th);
    r.junk   = junk;
    plan.push_back(r);
  endtask

  task automatic plan_bytes(input logic [7:0] base, input logic [7:0] stride,
                            input int unsigned count, input bit last, input bit typed,
                            input logic found, input logic [OFS_W-1:0] offset);
    plan_row_t r;
    r.setup       = 1'b0;
    r.base        = base;
    r.stride      = stride;
    r.count       = count;
    r.last        = last;
    r.typed       = typed;
    r.want.found  = found;
    r.want.offset = offset;
    plan.push_back(r);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random back-pressure plus the occasional long hold-off
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_hold      <= 0;
      squeeze_done <= 0;
    end else if (squeeze_req != squeeze_done) begin
      squeeze_done <= squeeze_done + 1;
      rx_hold      <= SQUEEZE_CYCLES - 1;
      res_ch.ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold      <= rx_hold - 1;
      res_ch.ready <= (rx_hold == 1);
    end else if (res_ch.valid && res_ch.ready) begin
      rx_gap = rx_idle ? $urandom_range(0, 5) : 0;
      rx_hold      <= rx_gap;
      res_ch.ready <= (rx_gap == 0);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string msg);
    n_bad++;
    if (n_bad <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // every result beat is matched against the oldest prediction
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (res_ch.found === 1'b1) n_found++;
      else n_missed++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: found %0d offset %0d",
                                  res_ch.found, res_ch.win_start));
      end else begin
        want = pending_verdicts.pop_front();
        if (res_ch.found !== want.found)
          report_mismatch($sformatf("found: expected %0d, got %0d",
                                    want.found, res_ch.found));
        if (res_ch.win_start !== want.offset)
          report_mismatch($sformatf("win_start: expected %0d, got %0d",
                                    want.offset, res_ch.win_start));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int unsigned phase;
    int unsigned nreg;
    int unsigned directed_bytes;
    int unsigned th;
    sig_mode_t   mode;
    bit          squeeze;
    plan_row_t   row;

    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_SIG_0_7;
    cfg_data           <= '0;
    byte_ch.valid      <= 1'b0;
    byte_ch.data_byte  <= 8'h00;
    byte_ch.region_end <= 1'b0;
    squeeze_req        <= 0;
    rx_idle            <= 1'b1;
    tx_idle             = 1'b1;

    mdl_sig    = '0;
    mdl_thresh = DEFAULT_THRESH;
    clear_region_model();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. Reset setting: all-zero signature, threshold 31.
    plan_bytes(8'h00, 8'h00, 1, 1, 1, 1'b0, 0);    // region shorter than the signature
    plan_bytes(8'h00, 8'h00, 32, 1, 1, 1'b1, 0);   // match on the closing byte
    // ramp signature, exact match needed, unused indexes written with junk
    plan_setup(SIG_RAMP, 32, 1);
    plan_bytes(8'hFF, 8'h00, 3, 0, 0, 1'b0, 0);
    plan_bytes(8'h00, 8'h01, 32, 0, 0, 1'b0, 0);   // match at offset 3
    plan_bytes(8'hFF, 8'h00, 4, 1, 0, 1'b0, 0);    // later bytes stay quiet
    // threshold beyond the signature length: nothing can match
    plan_setup(SIG_RAMP, 63, 0);
    plan_bytes(8'h00, 8'h01, 32, 1, 1, 1'b0, 0);
    plan_setup(SIG_RAMP, 33, 1);
    plan_bytes(8'h00, 8'h01, 40, 1, 1, 1'b0, 0);
    // threshold zero: first full window wins, whatever it holds
    plan_setup(SIG_ONES, 0, 0);
    plan_bytes(8'h5A, 8'h00, 32, 0, 1, 1'b1, 0);
    plan_bytes(8'hFF, 8'h00, 2, 1, 0, 1'b0, 0);
    // all-ones signature at the top threshold
    plan_setup(SIG_ONES, 32, 0);
    plan_bytes(8'h80, 8'h00, 20, 1, 1, 1'b0, 0);
    plan_bytes(8'h00, 8'h00, 5, 0, 0, 1'b0, 0);
    plan_bytes(8'hFF, 8'h00, 40, 1, 0, 1'b0, 0);   // match at offset 5
    plan_setup(SIG_RAMP, 30, 1);
    plan_bytes(8'h01, 8'h01, 31, 0, 0, 1'b0, 0);   // shifted ramp misses
    plan_bytes(8'h00, 8'h01, 33, 1, 0, 1'b0, 0);   // then an exact copy matches at offset 31

    foreach (plan[i]) begin
      row = plan[i];
      if (row.setup) begin
        settle();
        apply_setting(sig_pattern(row.mode), row.thresh, row.junk);
      end else begin
        for (int k = 0; k < row.count; k++)
          send_byte(row.base + 8'(k) * row.stride, row.last && k == row.count - 1,
                    row.typed && k == row.count - 1, row.want);
      end
    end
    directed_bytes = n_bytes;

    // Random phases: each gets a fresh setting; every fourth one piles up results
    // behind a long hold-off while bytes keep coming with no gaps.
    phase = 0;
    while (n_bytes - directed_bytes < RANDOM_BYTES) begin
      settle();
      case ($urandom_range(0, 9))
        0:       mode = SIG_ZERO;
        1:       mode = SIG_ONES;
        2, 3:    mode = SIG_COMMON;
        default: mode = SIG_RAND;
      endcase
      case ($urandom_range(0, 9))
        0:       th = 0;
        1:       th = SIG_LEN;
        2:       th = $urandom_range(SIG_LEN + 1, (1 << THRESH_W) - 1);
        3, 4:    th = $urandom_range(0, 27);
        default: th = $urandom_range(26, SIG_LEN);
      endcase
      apply_setting(sig_pattern(mode), THRESH_W'(th), $urandom_range(0, 3) == 0);
      squeeze = (phase % 4 == 0);
      tx_idle = squeeze ? 1'b0 : ($urandom_range(0, 3) != 0);
      rx_idle <= ($urandom_range(0, 3) != 0);
      if (squeeze) squeeze_req <= squeeze_req + 1;
      nreg = squeeze ? 24 : $urandom_range(2, 4);
      repeat (nreg) begin
        build_region(squeeze);
        send_region();
      end
      phase++;
    end

    settle();
    $display("ran %0d bytes in %0d regions across %0d register settings",
             n_bytes, n_regions, n_settings);
    $display("saw %0d matches and %0d misses; result side held off %0d times",
             n_found, n_missed, squeeze_done);
    if (n_bad == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
